// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the same cycle as its trigger
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Min-heap queue package
// Default sizes and result status codes of the heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int BMHQ_CAPACITY    = 64;
    localparam int BMHQ_KEY_BITS    = 16;
    localparam int BMHQ_HANDLE_BITS = 16;
    localparam int STATUS_BITS      = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// File: hdl/bmhq_in_if.sv
// ----------------------------------------------------------------------------
// Heap queue request channel
// Valid/ready channel carrying one push or pop request.
// ----------------------------------------------------------------------------
interface bmhq_in_if #(
    parameter int KEY_W    = 16,
    parameter int HANDLE_W = 16
);
    logic                valid;
    logic                ready;
    logic                mode;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output mode, output key, output handle, input ready);
    modport sink   (input valid, input mode, input key, input handle, output ready);
endinterface

// File: hdl/bmhq_out_if.sv
// ----------------------------------------------------------------------------
// Heap queue result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface bmhq_out_if #(
    parameter int KEY_W    = 16,
    parameter int HANDLE_W = 16,
    parameter int CNT_W    = 7
);
    import bmhq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KEY_W-1:0]       out_key;
    logic [HANDLE_W-1:0]    out_handle;
    logic [STATUS_BITS-1:0] status;
    logic [CNT_W-1:0]       occupancy;

    modport source (output valid, output out_key, output out_handle, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_key, input out_handle, input status,
                    input occupancy, output ready);
endinterface

// File: hdl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read; a same-address read returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/binary_min_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Fixed-capacity heap of (key, handle) entries held in one RAM; push sifts
// up from the tail, pop returns the root and sifts the last entry down.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              transfer
//  i_req    in   mode, key, handle                    valid & ready
//  o_rsp    out  out_key, out_handle, status, occup.  valid & ready
//
//  Push into an empty or full heap and pop on an empty one answer from idle; else
//  push climbs a level per parent compare and pop reads the root, the last entry
//  if one remains, then per node the left and any right child, and places the
//  entry in the final hole. Reset clears state, count and result valid; RAM stays
//  undefined, as only slots below the count are read. i_req.ready is high in idle
//  when the result register is free or drains in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_min_heap_queue_unit #(
    parameter int CAPACITY    = bmhq_pkg::BMHQ_CAPACITY,
    parameter int KEY_BITS    = bmhq_pkg::BMHQ_KEY_BITS,
    parameter int HANDLE_BITS = bmhq_pkg::BMHQ_HANDLE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmhq_in_if.sink      i_req,
    bmhq_out_if.source   o_rsp
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 1;
    localparam int EW = KEY_BITS + HANDLE_BITS;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_POP_ROOT = 7'b0000010,
        S_POP_LAST = 7'b0000100,
        S_UP       = 7'b0001000,
        S_DN_LEFT  = 7'b0010000,
        S_DN_RIGHT = 7'b0100000,
        S_PLACE    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_par, n_par;
    logic          r_op, n_op;
    logic [EW-1:0] r_cur, n_cur;
    logic [EW-1:0] r_left, n_left;
    logic [EW-1:0] r_root, n_root;

    logic                   r_out_valid, n_out_valid;
    logic [KEY_BITS-1:0]    r_out_key, n_out_key;
    logic [HANDLE_BITS-1:0] r_out_handle, n_out_handle;
    t_status                r_out_status, n_out_status;
    logic [CW-1:0]          r_out_occ, n_out_occ;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] rd_data;

    logic          in_fire;
    logic          out_free;
    logic [AW-1:0] tail_pos;
    logic [AW-1:0] par_pos;
    logic [AW-1:0] grand_pos;
    logic [LW-1:0] dn_left, dn_right, dn_idx, dn_nxt_left;
    logic          dn_take_right, dn_has_right, dn_swap;
    logic [EW-1:0] dn_pick;
    logic          up_swap;

    // entry RAM: key in the upper bits, handle below
    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // handshake
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_req.valid && i_req.ready;

    // index arithmetic
    assign tail_pos  = r_cnt[AW-1:0];
    assign par_pos   = (tail_pos - AW'(1)) >> 1;
    assign grand_pos = (r_par - AW'(1)) >> 1;
    assign up_swap   = r_cur[EW-1:HANDLE_BITS] < rd_data[EW-1:HANDLE_BITS];

    // child selection: left on ties, then swap only if strictly less
    assign dn_left       = {r_pos, 1'b1};
    assign dn_right      = dn_left + LW'(1);
    assign dn_has_right  = dn_right < LW'(r_cnt);
    assign dn_take_right = (r_state == S_DN_RIGHT) &&
                           (rd_data[EW-1:HANDLE_BITS] < r_left[EW-1:HANDLE_BITS]);
    assign dn_pick       = ((r_state == S_DN_RIGHT) && !dn_take_right) ? r_left : rd_data;
    assign dn_idx        = dn_take_right ? dn_right : dn_left;
    assign dn_nxt_left   = {dn_idx[AW-1:0], 1'b1};
    assign dn_swap       = dn_pick[EW-1:HANDLE_BITS] < r_cur[EW-1:HANDLE_BITS];

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_par        = r_par;
        n_op         = r_op;
        n_cur        = r_cur;
        n_left       = r_left;
        n_root       = r_root;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_key    = r_out_key;
        n_out_handle = r_out_handle;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_cur;
        ram_raddr    = r_par;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op         = i_req.mode;
                    n_out_key    = '0;
                    n_out_handle = '0;
                    n_out_status = ST_DONE;
                    n_out_occ    = r_cnt;
                    if (!i_req.mode) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            // refuse push on full heap
                            n_out_valid  = 1'b1;
                            n_out_status = ST_FULL;
                        end else begin
                            n_cur = {i_req.key, i_req.handle};
                            n_pos = tail_pos;
                            n_cnt = r_cnt + CW'(1);
                            if (r_cnt == '0) begin
                                // first entry goes straight to the root
                                ram_we      = 1'b1;
                                ram_waddr   = '0;
                                ram_wdata   = {i_req.key, i_req.handle};
                                n_out_valid = 1'b1;
                                n_out_occ   = r_cnt + CW'(1);
                            end else begin
                                ram_raddr = par_pos;
                                n_par     = par_pos;
                                n_state   = S_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_EMPTY;
                        end else begin
                            ram_raddr = '0;
                            n_cnt     = r_cnt - CW'(1);
                            n_state   = S_POP_ROOT;
                        end
                    end
                end
            end

            S_POP_ROOT: begin
                n_root = rd_data;
                if (r_cnt == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = rd_data[EW-1:HANDLE_BITS];
                    n_out_handle = rd_data[HANDLE_BITS-1:0];
                    n_out_occ    = r_cnt;
                    n_state      = S_IDLE;
                end else begin
                    // fetch the last entry, now one past the count
                    ram_raddr = tail_pos;
                    n_state   = S_POP_LAST;
                end
            end

            S_POP_LAST: begin
                n_cur = rd_data;
                n_pos = '0;
                if (r_cnt == CW'(1)) begin
                    ram_we       = 1'b1;
                    ram_waddr    = '0;
                    ram_wdata    = rd_data;
                    n_out_valid  = 1'b1;
                    n_out_key    = r_root[EW-1:HANDLE_BITS];
                    n_out_handle = r_root[HANDLE_BITS-1:0];
                    n_out_occ    = r_cnt;
                    n_state      = S_IDLE;
                end else begin
                    ram_raddr = AW'(1);
                    n_state   = S_DN_LEFT;
                end
            end

            S_UP: begin
                if (up_swap) begin
                    // move parent down into the hole, climb one level
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = rd_data;
                    n_pos     = r_par;
                    if (r_par == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_raddr = grand_pos;
                        n_par     = grand_pos;
                    end
                end else begin
                    ram_we      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_occ   = r_cnt;
                    n_state     = S_IDLE;
                end
            end

            S_DN_LEFT, S_DN_RIGHT: begin
                if ((r_state == S_DN_LEFT) && dn_has_right) begin
                    // hold left child, fetch right child
                    n_left    = rd_data;
                    ram_raddr = dn_right[AW-1:0];
                    n_state   = S_DN_RIGHT;
                end else if (dn_swap) begin
                    // move chosen child up into the hole, descend one level
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = dn_pick;
                    n_pos     = dn_idx[AW-1:0];
                    if (dn_nxt_left < LW'(r_cnt)) begin
                        ram_raddr = dn_nxt_left[AW-1:0];
                        n_state   = S_DN_LEFT;
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    ram_we       = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_key    = r_root[EW-1:HANDLE_BITS];
                    n_out_handle = r_root[HANDLE_BITS-1:0];
                    n_out_occ    = r_cnt;
                    n_state      = S_IDLE;
                end
            end

            S_PLACE: begin
                // drop the held entry into the final hole
                ram_we      = 1'b1;
                n_out_valid = 1'b1;
                n_out_occ   = r_cnt;
                if (r_op) begin
                    n_out_key    = r_root[EW-1:HANDLE_BITS];
                    n_out_handle = r_root[HANDLE_BITS-1:0];
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_par        <= n_par;
        r_op         <= n_op;
        r_cur        <= n_cur;
        r_left       <= n_left;
        r_root       <= n_root;
        r_out_key    <= n_out_key;
        r_out_handle <= n_out_handle;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.out_key    = r_out_key;
    assign o_rsp.out_handle = r_out_handle;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.occupancy  = r_out_occ;

    // checks
    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= CW'(CAPACITY), "count above capacity")
    `ASSERT_IMPL(a_busy_no_rsp, i_clk, i_rst_n, r_state != S_IDLE, !r_out_valid, "result pending while busy")
    `ASSERT_IMPL(a_we_owner, i_clk, i_rst_n, ram_we, (r_state != S_IDLE) || in_fire, "RAM write while idle")
    `ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !in_fire, $stable(r_cnt), "count moved without request")

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min-heap queue testbench
// Drives push and pop requests into the heap queue under several handshake
// idling phases and checks every result against a shadow heap kept here.
// ----------------------------------------------------------------------------
module tb;
    import bmhq_pkg::*;

    localparam int KW        = BMHQ_KEY_BITS;
    localparam int HW        = BMHQ_HANDLE_BITS;
    localparam int CW        = $clog2(BMHQ_CAPACITY + 1);
    localparam int ITEMS     = 400;
    localparam int WDOG_MAX  = 5000;
    localparam int TAIL_WAIT = 50;
    localparam int MAX_SHOWN = 10;

    localparam bit MODE_PUSH = 1'b0;
    localparam bit MODE_POP  = 1'b1;

    // idling phases of the two channels
    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } t_phase;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [HW-1:0] handle;
        t_status       status;
        logic [CW-1:0] occupancy;
    } t_heap_result;

    // ------------------------------------------------------------------------
    // Shadow heap: predicts each result and checks the block's results
    // ------------------------------------------------------------------------
    class heap_shadow;
        logic [KW-1:0] keys[BMHQ_CAPACITY];
        logic [HW-1:0] handles[BMHQ_CAPACITY];
        int unsigned   count;
        t_heap_result  pending_results[$];
        int unsigned   mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [KW-1:0] tk;
            logic [HW-1:0] th;
            tk         = keys[a];
            th         = handles[a];
            keys[a]    = keys[b];
            handles[a] = handles[b];
            keys[b]    = tk;
            handles[b] = th;
        endfunction

        // apply one accepted request and queue the result it must give
        function void note_request(bit mode, logic [KW-1:0] key, logic [HW-1:0] handle);
            t_heap_result res;
            int unsigned  pos;
            int unsigned  left;
            int unsigned  pick;
            res = '{key: '0, handle: '0, status: ST_DONE, occupancy: '0};
            if (mode == MODE_PUSH) begin
                if (count >= BMHQ_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    keys[count]    = key;
                    handles[count] = handle;
                    pos            = count;
                    count++;
                    // sift up while strictly below the parent
                    while (pos > 0 && keys[pos] < keys[(pos - 1) >> 1]) begin
                        swap_slots(pos, (pos - 1) >> 1);
                        pos = (pos - 1) >> 1;
                    end
                end
            end else if (count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.key    = keys[0];
                res.handle = handles[0];
                count--;
                if (count > 0) begin
                    keys[0]    = keys[count];
                    handles[0] = handles[count];
                    pos        = 0;
                    // sift down toward the smaller child, left on ties
                    forever begin
                        left = 2 * pos + 1;
                        if (left >= count) break;
                        pick = left;
                        if (left + 1 < count && keys[left + 1] < keys[left])
                            pick = left + 1;
                        if (keys[pick] < keys[pos]) begin
                            swap_slots(pos, pick);
                            pos = pick;
                        end else begin
                            break;
                        end
                    end
                end
            end
            res.occupancy = CW'(count);
            pending_results.push_back(res);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // compare one transferred result with the oldest prediction
        function void check_result(logic [KW-1:0] key, logic [HW-1:0] handle,
                                   logic [STATUS_BITS-1:0] status, logic [CW-1:0] occupancy);
            t_heap_result exp;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result key=%h handle=%h status=%0d occ=%0d",
                                 key, handle, status, occupancy));
                return;
            end
            exp = pending_results.pop_front();
            if (key !== exp.key)
                report($sformatf("out_key exp %h got %h", exp.key, key));
            if (handle !== exp.handle)
                report($sformatf("out_handle exp %h got %h", exp.handle, handle));
            if (status !== exp.status)
                report($sformatf("status exp %0d got %0d", exp.status, status));
            if (occupancy !== exp.occupancy)
                report($sformatf("occupancy exp %0d got %0d", exp.occupancy, occupancy));
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    t_phase     phase;
    heap_shadow shadow;
    int         idle_cycles;
    int unsigned sent;

    bmhq_in_if  #(.KEY_W(KW), .HANDLE_W(HW))              req_if ();
    bmhq_out_if #(.KEY_W(KW), .HANDLE_W(HW), .CNT_W(CW))  rsp_if ();

    binary_min_heap_queue_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // clock generation
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // check result transfers, toggle receiver stalls, run the watchdog
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            shadow.check_result(rsp_if.out_key, rsp_if.out_handle, rsp_if.status,
                                rsp_if.occupancy);
        if (phase == PH_RECV_STALL)
            rsp_if.ready <= ($urandom_range(99) >= 59);
        else if (phase == PH_BOTH)
            rsp_if.ready <= ($urandom_range(99) >= 31);
        else
            rsp_if.ready <= 1'b1;
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb failed");
            $finish;
        end
    end

    // key draw biased toward a narrow range so ties are frequent
    function automatic logic [KW-1:0] pick_key();
        if ($urandom_range(3) == 0)
            return KW'($urandom_range(7));
        return KW'($urandom_range((1 << KW) - 1));
    endfunction

    // send one request, idling first when the phase asks for it
    task automatic send_request(input bit mode, input logic [KW-1:0] key,
                                input logic [HW-1:0] handle);
        int unsigned idle_pct;
        idle_pct = (phase == PH_SEND_IDLE) ? 59 : (phase == PH_BOTH) ? 31 : 0;
        if ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_if.valid  <= 1'b1;
        req_if.mode   <= mode;
        req_if.key    <= key;
        req_if.handle <= handle;
        do @(posedge clk); while (!req_if.ready);
        shadow.note_request(mode, key, handle);
        sent++;
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge clk);
    endtask

    initial begin
        int unsigned burst;
        int unsigned n;
        clk           = 1'b0;
        rst_n         = 1'b0;
        phase         = PH_FREE;
        idle_cycles   = 0;
        sent          = 0;
        shadow        = new();
        req_if.valid  = 1'b0;
        req_if.mode   = MODE_PUSH;
        req_if.key    = '0;
        req_if.handle = '0;
        rsp_if.ready  = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, field extremes, equal keys, drain past empty
        send_request(MODE_POP,  '0,     '0);
        send_request(MODE_PUSH, '1,     '1);
        send_request(MODE_PUSH, '0,     '0);
        send_request(MODE_PUSH, 16'h8000, 16'haaaa);
        send_request(MODE_PUSH, 16'h8000, 16'h5555);
        send_request(MODE_PUSH, 16'h8000, 16'h1234);
        send_request(MODE_PUSH, 16'h0001, 16'hffff);
        send_request(MODE_PUSH, 16'hfffe, 16'h0001);
        repeat (8) send_request(MODE_POP, '0, '0);
        send_request(MODE_PUSH, 16'd5, 16'd1);
        send_request(MODE_PUSH, 16'd5, 16'd2);
        send_request(MODE_PUSH, 16'd5, 16'd3);
        repeat (3) send_request(MODE_POP, 16'hffff, 16'hffff);
        wait_drained();

        // random bursts: fill past full, drain past empty, or mixed traffic
        while (sent < ITEMS) begin
            phase = t_phase'((sent / 60) % 4);
            burst = $urandom_range(9);
            if (burst < 2) begin
                while (shadow.count < BMHQ_CAPACITY)
                    send_request(MODE_PUSH, pick_key(), HW'($urandom));
                repeat ($urandom_range(1, 2))
                    send_request(MODE_PUSH, pick_key(), HW'($urandom));
            end else if (burst < 4) begin
                while (shadow.count > 0)
                    send_request(MODE_POP, pick_key(), HW'($urandom));
                send_request(MODE_POP, pick_key(), HW'($urandom));
                wait_drained();
            end else begin
                n = $urandom_range(5, 20);
                repeat (n)
                    send_request(($urandom_range(99) >= 55) ? MODE_POP : MODE_PUSH,
                                 pick_key(), HW'($urandom));
            end
        end

        // let the last results drain, then allow for the block's latency
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/bmhq_pkg.sv
hdl/bmhq_in_if.sv
hdl/bmhq_out_if.sv
hdl/bmhq_ram.sv
hdl/binary_min_heap_queue_unit.sv
dv/tb.sv
